/* src/twhsm_pkg.sv */
// Shared types and constants for the two-wire humidity sensor master.
// Beat layouts, function and error codes, sensor command bytes.
// No dependencies.
package twhsm_pkg;

  typedef struct packed {
    logic       start_req;
    logic [2:0] func;
    logic [7:0] write_value;
    logic       data_line;
  } twhsm_in_t;

  typedef struct packed {
    logic        sck;
    logic        data_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  error_code;
    logic [15:0] read_value;
    logic        low_resolution;
  } twhsm_res_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [31:0] timeout_ticks;
  } twhsm_cfg_t;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrNoAck   = 2'd1,
    ErrTimeout = 2'd2
  } twhsm_err_e;

  // operation codes
  localparam logic [2:0] FuncReadTemp   = 3'd0;
  localparam logic [2:0] FuncReadHum    = 3'd1;
  localparam logic [2:0] FuncReadStat   = 3'd2;
  localparam logic [2:0] FuncWriteStat  = 3'd3;
  localparam logic [2:0] FuncSoftReset  = 3'd4;
  localparam logic [2:0] FuncConnReset  = 3'd5;

  // register indexes
  localparam logic CfgHalfPeriod = 1'b0;
  localparam logic CfgTimeout    = 1'b1;

  // sensor command bytes
  localparam logic [7:0] CmdReadTemp  = 8'h03;
  localparam logic [7:0] CmdReadHum   = 8'h05;
  localparam logic [7:0] CmdReadStat  = 8'h07;
  localparam logic [7:0] CmdWriteStat = 8'h06;
  localparam logic [7:0] CmdSoftReset = 8'h1E;
  localparam logic [7:0] WriteMask    = 8'h07;

  localparam logic [3:0]  ResetPulses   = 4'd10;
  localparam logic [3:0]  BitsPerByte   = 4'd8;
  localparam logic [15:0] HalfPeriodRst = 16'd10;
  localparam logic [31:0] TimeoutRst    = 32'd1000000;

  function automatic logic [7:0] cmd_byte(input logic [2:0] op);
    logic [7:0] c;
    unique case (op)
      FuncReadTemp:  c = CmdReadTemp;
      FuncReadHum:   c = CmdReadHum;
      FuncReadStat:  c = CmdReadStat;
      FuncWriteStat: c = CmdWriteStat;
      FuncSoftReset: c = CmdSoftReset;
      default:       c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* src/twhsm_cfg.sv */
// Configuration registers: half period and measurement timeout.
// Depends on twhsm_pkg.
module twhsm_cfg import twhsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output twhsm_cfg_t  cfg_o
);

  twhsm_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPeriod: cfg_d.half_period_ticks = cfg_data_i[15:0];
        CfgTimeout:    cfg_d.timeout_ticks     = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HalfPeriodRst;
      cfg_q.timeout_ticks     <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/twhsm_core.sv */
// Bus sequencer: state registers and the per-tick next-state logic.
// Gives the result of each accepted tick combinationally. Depends on twhsm_pkg.
module twhsm_core import twhsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  twhsm_in_t  in_i,
  input  twhsm_cfg_t cfg_i,
  output twhsm_res_t res_o
);

  typedef enum logic [4:0] {
    PhIdle   = 5'd0,
    PhRstPre = 5'd1,
    PhRstLo  = 5'd2,
    PhRstHi  = 5'd3,
    PhTs     = 5'd4,
    PhTxLo   = 5'd5,
    PhTxHi   = 5'd6,
    PhTxaLo  = 5'd7,
    PhTxaHi  = 5'd8,
    PhWait   = 5'd9,
    PhRxLo   = 5'd10,
    PhRxHi   = 5'd11,
    PhRxaLo  = 5'd12,
    PhRxaHi  = 5'd13
  } phase_e;

  phase_e      phase_d, phase_q;
  logic [2:0]  op_d, op_q;
  logic [3:0]  bit_d, bit_q;
  logic [15:0] shift_d, shift_q;
  logic [15:0] tick_d, tick_q;
  logic [31:0] wait_d, wait_q;
  logic [3:0]  pulse_d, pulse_q;
  logic        resfl_d, resfl_q;
  logic        sck_d, sck_q;
  logic        dlow_d, dlow_q;

  logic        fin;
  twhsm_err_e  fin_err;
  logic [15:0] tick_inc;
  logic [31:0] wait_inc;
  logic [3:0]  nb;
  logic [3:0]  np;
  logic [7:0]  tx_byte;
  logic [15:0] value;

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    tick_d   = tick_q;
    wait_d   = wait_q;
    pulse_d  = pulse_q;
    resfl_d  = resfl_q;
    sck_d    = sck_q;
    dlow_d   = dlow_q;
    fin      = 1'b0;
    fin_err  = ErrNone;
    tick_inc = tick_q + 16'd1;
    wait_inc = wait_q + 32'd1;
    nb       = bit_q + 4'd1;
    np       = pulse_q + 4'd1;
    tx_byte  = 8'h00;
    value    = 16'h0000;

    if (phase_q == PhIdle) begin
      if (in_i.start_req && (in_i.func <= FuncConnReset)) begin
        op_d    = in_i.func;
        tick_d  = 16'd0;
        wait_d  = 32'd0;
        pulse_d = 4'd0;
        bit_d   = 4'd0;
        shift_d = {8'h00, in_i.write_value};
        sck_d   = 1'b0;
        dlow_d  = 1'b0;
        phase_d = (in_i.func >= FuncSoftReset) ? PhRstPre : PhTs;
      end
    end else if (phase_q == PhWait) begin
      if (!in_i.data_line) begin
        shift_d = 16'h0000;
        pulse_d = 4'd0;
        bit_d   = 4'd0;
        phase_d = PhRxLo;
      end else begin
        wait_d = wait_inc;
        if (wait_inc >= cfg_i.timeout_ticks) begin
          fin     = 1'b1;
          fin_err = ErrTimeout;
        end
      end
    end else begin
      tick_d = tick_inc;
      if (tick_inc >= cfg_i.half_period_ticks) begin
        tick_d = 16'd0;
        unique case (phase_q)
          PhRstPre: begin
            sck_d   = 1'b0;
            phase_d = PhRstLo;
          end
          PhRstLo: begin
            sck_d   = 1'b1;
            phase_d = PhRstHi;
          end
          PhRstHi: begin
            sck_d   = 1'b0;
            pulse_d = np;
            if (np >= ResetPulses) begin
              if (op_q == FuncConnReset) begin
                fin = 1'b1;
              end else begin
                pulse_d = 4'd0;
                bit_d   = 4'd0;
                phase_d = PhTs;
              end
            end else begin
              phase_d = PhRstLo;
            end
          end
          PhTs: begin
            // transmission start: sck up, data down, sck down, sck up, data up, sck down
            unique case (bit_q)
              4'd0:    sck_d  = 1'b1;
              4'd1:    dlow_d = 1'b1;
              4'd2:    sck_d  = 1'b0;
              4'd3:    sck_d  = 1'b1;
              4'd4:    dlow_d = 1'b0;
              default: sck_d  = 1'b0;
            endcase
            if (bit_q >= 4'd5) begin
              tx_byte = cmd_byte(op_q);
              pulse_d = 4'd0;
              shift_d = {tx_byte, shift_q[7:0]};
              bit_d   = 4'd0;
              dlow_d  = ~tx_byte[7];
              phase_d = PhTxLo;
            end else begin
              bit_d = nb;
            end
          end
          PhTxLo: begin
            sck_d   = 1'b1;
            phase_d = PhTxHi;
          end
          PhTxHi: begin
            sck_d = 1'b0;
            bit_d = nb;
            if (nb < BitsPerByte) begin
              // msb first: bit 15 - nb of the shift register
              dlow_d  = ~shift_q[{1'b1, ~nb[2:0]}];
              phase_d = PhTxLo;
            end else begin
              dlow_d  = 1'b0;
              phase_d = PhTxaLo;
            end
          end
          PhTxaLo: begin
            sck_d   = 1'b1;
            phase_d = PhTxaHi;
          end
          PhTxaHi: begin
            sck_d = 1'b0;
            if (in_i.data_line) begin
              fin     = 1'b1;
              fin_err = ErrNoAck;
            end else begin
              priority if (op_q == FuncReadTemp || op_q == FuncReadHum) begin
                wait_d  = 32'd0;
                phase_d = PhWait;
              end else if (op_q == FuncReadStat) begin
                shift_d = 16'h0000;
                pulse_d = 4'd0;
                bit_d   = 4'd0;
                phase_d = PhRxLo;
              end else if (op_q == FuncWriteStat) begin
                if (pulse_q == 4'd0) begin
                  tx_byte = shift_q[7:0] & WriteMask;
                  pulse_d = 4'd1;
                  shift_d = {tx_byte, shift_q[7:0]};
                  bit_d   = 4'd0;
                  dlow_d  = ~tx_byte[7];
                  phase_d = PhTxLo;
                end else begin
                  resfl_d = shift_q[0];
                  fin     = 1'b1;
                end
              end else begin
                resfl_d = 1'b0;
                fin     = 1'b1;
              end
            end
          end
          PhRxLo: begin
            sck_d   = 1'b1;
            phase_d = PhRxHi;
          end
          PhRxHi: begin
            shift_d = {shift_q[14:0], in_i.data_line};
            sck_d   = 1'b0;
            bit_d   = nb;
            if (nb < BitsPerByte) begin
              phase_d = PhRxLo;
            end else if (op_q == FuncReadStat || pulse_q == 4'd0) begin
              dlow_d  = 1'b1;
              phase_d = PhRxaLo;
            end else begin
              // last byte of a measurement, crc skipped
              fin = 1'b1;
            end
          end
          PhRxaLo: begin
            sck_d   = 1'b1;
            phase_d = PhRxaHi;
          end
          PhRxaHi: begin
            sck_d  = 1'b0;
            dlow_d = 1'b0;
            if (pulse_q == 4'd0) begin
              pulse_d = 4'd1;
              bit_d   = 4'd0;
              phase_d = PhRxLo;
            end else begin
              if (op_q == FuncReadStat) begin
                resfl_d = shift_q[8];
              end
              fin = 1'b1;
            end
          end
          default: begin
            phase_d = PhIdle;
            sck_d   = 1'b0;
            dlow_d  = 1'b0;
          end
        endcase
      end
    end

    if (fin) begin
      phase_d = PhIdle;
      sck_d   = 1'b0;
      dlow_d  = 1'b0;
      if (fin_err == ErrNone) begin
        if (op_q == FuncReadTemp || op_q == FuncReadHum) begin
          value = shift_d;
        end else if (op_q == FuncReadStat) begin
          value = {8'h00, shift_d[15:8]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      op_q    <= 3'd0;
      bit_q   <= 4'd0;
      shift_q <= 16'h0000;
      tick_q  <= 16'd0;
      wait_q  <= 32'd0;
      pulse_q <= 4'd0;
      resfl_q <= 1'b0;
      sck_q   <= 1'b0;
      dlow_q  <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      wait_q  <= wait_d;
      pulse_q <= pulse_d;
      resfl_q <= resfl_d;
      sck_q   <= sck_d;
      dlow_q  <= dlow_d;
    end
  end

  assign res_o.sck            = sck_d;
  assign res_o.data_low       = dlow_d;
  assign res_o.busy_res       = (phase_d != PhIdle);
  assign res_o.done_res       = fin;
  assign res_o.error_code     = fin_err;
  assign res_o.read_value     = value;
  assign res_o.low_resolution = resfl_d;

endmodule

/* src/twhsm_out_buf.sv */
// Result register with a skid stage, so a tick is taken while a result waits.
// Depends on twhsm_pkg.
module twhsm_out_buf import twhsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  twhsm_res_t data_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output twhsm_res_t out_data_o
);

  logic       out_valid_d, out_valid_q;
  logic       skid_valid_d, skid_valid_q;
  twhsm_res_t out_data_d, out_data_q;
  twhsm_res_t skid_d, skid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_d       = skid_q;
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_d   = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        if (push_i) begin
          out_data_d = data_i;
        end
      end
    end else if (push_i) begin
      // output stalled: park the beat
      skid_valid_d = 1'b1;
      skid_d       = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    skid_q     <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/two_wire_humidity_sensor_master.sv */
// Two-wire humidity sensor bus master, one time tick per input beat.
// The result of an accepted tick is registered in the output stage.
// Throughput: one tick per cycle while input is ready; a two-entry output stage
// keeps input ready while only one result is held on a stalled output.
// Reset: asynchronous, idle bus (sck low, data released), registers at defaults.
module two_wire_humidity_sensor_master import twhsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  twhsm_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output twhsm_res_t  out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  twhsm_cfg_t cfg;
  twhsm_res_t res;
  logic       accept;

  assign accept = in_valid_i && in_ready_o;

  twhsm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  twhsm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  twhsm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/twhsm_checker.sv */
// Scoreboard for the two-wire humidity sensor master: keeps its own model of
// the bus sequencer, predicts one result beat per tick beat and compares.
// Depends on twhsm_pkg for beat layouts, codes and register defaults.
module twhsm_checker import twhsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  twhsm_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  twhsm_res_t out_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef enum logic [4:0] {
    PhIdle, PhRstPre, PhRstLo, PhRstHi, PhStart, PhTxLo, PhTxHi, PhAckLo, PhAckHi,
    PhWait, PhRxLo, PhRxHi, PhMackLo, PhMackHi
  } bus_phase_e;

  twhsm_cfg_t  regs;
  bus_phase_e  ph;
  logic [2:0]  op;
  logic [3:0]  bit_cnt;
  logic [3:0]  pulse_cnt;
  logic [15:0] shreg;
  logic [15:0] tick_cnt;
  logic [31:0] wait_cnt;
  logic        res_flag;
  logic        sck_q;
  logic        dlow_q;
  twhsm_res_t  res;
  twhsm_res_t  want;
  twhsm_res_t  bus_results_q[$];

  function automatic void end_op(input twhsm_err_e e);
    ph = PhIdle;
    sck_q = 1'b0;
    dlow_q = 1'b0;
    res.done_res = 1'b1;
    res.error_code = e;
    res.read_value = '0;
    if (e == ErrNone) begin
      if (op == FuncReadTemp || op == FuncReadHum) res.read_value = shreg;
      else if (op == FuncReadStat) res.read_value = {8'h00, shreg[15:8]};
    end
  endfunction

  // data is open drain: a zero bit pulls the line low
  function automatic void put_bit();
    dlow_q = ~shreg[{1'b1, ~bit_cnt[2:0]}];
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    shreg = {b, shreg[7:0]};
    bit_cnt = '0;
    ph = PhTxLo;
    put_bit();
  endfunction

  function automatic void start_rx();
    shreg = '0;
    pulse_cnt = '0;
    bit_cnt = '0;
    ph = PhRxLo;
  endfunction

  function automatic void byte_acked();
    case (op)
      FuncReadTemp, FuncReadHum: begin
        wait_cnt = '0;
        ph = PhWait;
      end
      FuncReadStat: start_rx();
      FuncWriteStat: begin
        // pulse_cnt doubles as the byte index once the reset pulses are over
        if (pulse_cnt == 4'd0) begin
          pulse_cnt = 4'd1;
          load_byte(shreg[7:0] & WriteMask);
        end else begin
          res_flag = shreg[0];
          end_op(ErrNone);
        end
      end
      default: begin
        res_flag = 1'b0;
        end_op(ErrNone);
      end
    endcase
  endfunction

  function automatic void byte_received();
    if (pulse_cnt == 4'd0) begin
      pulse_cnt = 4'd1;
      bit_cnt = '0;
      ph = PhRxLo;
    end else begin
      if (op == FuncReadStat) res_flag = shreg[8];
      end_op(ErrNone);
    end
  endfunction

  function automatic void advance(input logic dl);
    case (ph)
      PhRstPre: begin
        sck_q = 1'b0;
        ph = PhRstLo;
      end
      PhRstLo: begin
        sck_q = 1'b1;
        ph = PhRstHi;
      end
      PhRstHi: begin
        sck_q = 1'b0;
        pulse_cnt = pulse_cnt + 4'd1;
        if (pulse_cnt >= ResetPulses) begin
          if (op == FuncConnReset) begin
            end_op(ErrNone);
          end else begin
            pulse_cnt = '0;
            bit_cnt = '0;
            ph = PhStart;
          end
        end else begin
          ph = PhRstLo;
        end
      end
      PhStart: begin
        // transmission start: sck up, data down, sck down, sck up, data up, sck down
        case (bit_cnt)
          4'd0: sck_q = 1'b1;
          4'd1: dlow_q = 1'b1;
          4'd2: sck_q = 1'b0;
          4'd3: sck_q = 1'b1;
          4'd4: dlow_q = 1'b0;
          default: sck_q = 1'b0;
        endcase
        if (bit_cnt >= 4'd5) begin
          pulse_cnt = '0;
          case (op)
            FuncReadTemp:  load_byte(CmdReadTemp);
            FuncReadHum:   load_byte(CmdReadHum);
            FuncReadStat:  load_byte(CmdReadStat);
            FuncWriteStat: load_byte(CmdWriteStat);
            FuncSoftReset: load_byte(CmdSoftReset);
            default:       load_byte('0);
          endcase
        end else begin
          bit_cnt = bit_cnt + 4'd1;
        end
      end
      PhTxLo: begin
        sck_q = 1'b1;
        ph = PhTxHi;
      end
      PhTxHi: begin
        sck_q = 1'b0;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < BitsPerByte) begin
          put_bit();
          ph = PhTxLo;
        end else begin
          dlow_q = 1'b0;
          ph = PhAckLo;
        end
      end
      PhAckLo: begin
        sck_q = 1'b1;
        ph = PhAckHi;
      end
      PhAckHi: begin
        sck_q = 1'b0;
        if (dl) end_op(ErrNoAck);
        else byte_acked();
      end
      PhRxLo: begin
        sck_q = 1'b1;
        ph = PhRxHi;
      end
      PhRxHi: begin
        shreg = {shreg[14:0], dl};
        sck_q = 1'b0;
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < BitsPerByte) begin
          ph = PhRxLo;
        end else if (op == FuncReadStat || pulse_cnt == 4'd0) begin
          // master acknowledges; the measurement lsb goes unacked to skip the crc
          dlow_q = 1'b1;
          ph = PhMackLo;
        end else begin
          byte_received();
        end
      end
      PhMackLo: begin
        sck_q = 1'b1;
        ph = PhMackHi;
      end
      PhMackHi: begin
        sck_q = 1'b0;
        dlow_q = 1'b0;
        byte_received();
      end
      default: begin
        ph = PhIdle;
        sck_q = 1'b0;
        dlow_q = 1'b0;
      end
    endcase
  endfunction

  function automatic twhsm_res_t sensor_tick(input twhsm_in_t t);
    res = '0;
    if (ph == PhIdle) begin
      if (t.start_req && t.func <= FuncConnReset) begin
        op = t.func;
        tick_cnt = '0;
        wait_cnt = '0;
        pulse_cnt = '0;
        bit_cnt = '0;
        shreg = {8'h00, t.write_value};
        sck_q = 1'b0;
        dlow_q = 1'b0;
        ph = (t.func >= FuncSoftReset) ? PhRstPre : PhStart;
      end
    end else if (ph == PhWait) begin
      // sensor pulls data low once the measurement is ready
      if (!t.data_line) begin
        start_rx();
      end else begin
        wait_cnt = wait_cnt + 32'd1;
        if (wait_cnt >= regs.timeout_ticks) end_op(ErrTimeout);
      end
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= regs.half_period_ticks) begin
        tick_cnt = '0;
        advance(t.data_line);
      end
    end
    res.sck = sck_q;
    res.data_low = dlow_q;
    res.busy_res = (ph != PhIdle);
    res.low_resolution = res_flag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.half_period_ticks = HalfPeriodRst;
      regs.timeout_ticks = TimeoutRst;
      ph = PhIdle;
      op = '0;
      bit_cnt = '0;
      pulse_cnt = '0;
      shreg = '0;
      tick_cnt = '0;
      wait_cnt = '0;
      res_flag = 1'b0;
      sck_q = 1'b0;
      dlow_q = 1'b0;
      bus_results_q.delete();
      mismatch_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHalfPeriod: regs.half_period_ticks = cfg_data_i[15:0];
          CfgTimeout:    regs.timeout_ticks = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) bus_results_q.push_back(sensor_tick(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (bus_results_q.size() == 0) begin
          mismatch_count_o = mismatch_count_o + 1;
          if (mismatch_count_o <= 10) $display("unexpected bus beat: %p", out_data_i);
        end else begin
          want = bus_results_q.pop_front();
          if (out_data_i !== want) begin
            mismatch_count_o = mismatch_count_o + 1;
            if (mismatch_count_o <= 10)
              $display("bus beat mismatch\n  expected %p\n  got      %p", want, out_data_i);
          end
        end
      end
      pending_o = bus_results_q.size();
    end
  end

endmodule

/* tb/two_wire_humidity_sensor_master_test.sv */
// Top of the two-wire humidity sensor master bench: clock, reset, tick and
// register stimulus, a stalling result sink, watchdog and verdict.
// Depends on twhsm_pkg, the master itself and twhsm_checker.
module two_wire_humidity_sensor_master_test;
  import twhsm_pkg::*;

  localparam int StallLimit = 1000;
  localparam logic [2:0] FuncUndefLo = FuncConnReset + 3'd1;
  localparam logic [2:0] FuncUndefHi = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  twhsm_in_t   in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  twhsm_res_t  out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CfgHalfPeriod;
  logic [31:0] cfg_data = '0;

  int mismatches;
  int pending;
  int in_cnt = 0;
  int out_cnt = 0;
  int quiet = 0;

  // per phase: half period, timeout, number of ticks
  logic [15:0] hp_tab [7] = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd1, 16'd3, 16'd10};
  logic [31:0] to_tab [7] = '{32'd3, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd20,
                              32'd1000000};
  int          n_tab  [7] = '{300, 250, 250, 60, 250, 250, 150};

  two_wire_humidity_sensor_master u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  twhsm_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) in_cnt <= in_cnt + 1;
    if (out_valid && out_ready) out_cnt <= out_cnt + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  always @(negedge clk) begin
    if (quiet >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result sink: segments of steady, patterned or random stalls, one long hold
  initial begin : sink
    int seg;
    int mode;
    int cycles;
    bit held;
    cycles = 0;
    held = 1'b0;
    forever begin
      if (!held && cycles > 500) begin
        held = 1'b1;
        repeat (80) begin
          @(negedge clk);
          out_ready <= 1'b0;
          cycles++;
        end
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(10, 80);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 99) < 70);
          2: out_ready <= (cycles % 3 != 0);
          default: out_ready <= ($urandom_range(0, 99) < 30);
        endcase
        cycles++;
      end
    end
  end

  function automatic twhsm_in_t mk_tick(input logic s, input logic [2:0] f,
                                        input logic [7:0] v, input logic d);
    twhsm_in_t t;
    t.start_req = s;
    t.func = f;
    t.write_value = v;
    t.data_line = d;
    return t;
  endfunction

  task automatic drive_tick(input twhsm_in_t t);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // hold the sender until every result beat has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (in_cnt != out_cnt) @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] hp, input logic [31:0] to);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CfgHalfPeriod;
    cfg_data <= {16'h0000, hp};
    @(negedge clk);
    cfg_idx <= CfgTimeout;
    cfg_data <= to;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // bursts of ticks, each with its own bias on the sampled data line
  task automatic run_phase(input int n);
    int sent;
    int burst;
    int low_pct;
    twhsm_in_t t;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      case ($urandom_range(0, 5))
        0: low_pct = 100;
        1: low_pct = 95;
        2: low_pct = 80;
        3: low_pct = 50;
        4: low_pct = 20;
        default: low_pct = 0;
      endcase
      repeat (burst) begin
        t.start_req = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0) t.func = 3'($urandom_range(FuncUndefLo, FuncUndefHi));
        else t.func = 3'($urandom_range(FuncReadTemp, FuncConnReset));
        t.write_value = 8'($urandom);
        t.data_line = ($urandom_range(0, 99) >= low_pct);
        drive_tick(t);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero half period and timeout, undefined functions, a connection reset
    // with starts offered throughout while busy
    set_regs(16'd0, 32'd0);
    drive_tick(mk_tick(1'b0, FuncReadTemp, 8'h00, 1'b1));
    drive_tick(mk_tick(1'b1, FuncUndefHi, 8'hFF, 1'b0));
    drive_tick(mk_tick(1'b1, FuncUndefLo, 8'h00, 1'b1));
    drive_tick(mk_tick(1'b1, FuncConnReset, 8'hFF, 1'b1));
    for (i = 0; i < 21; i++) drive_tick(mk_tick(1'b1, FuncReadTemp, 8'($urandom), i[0]));

    for (i = 0; i < 7; i++) begin
      drain();
      set_regs(hp_tab[i], to_tab[i]);
      run_phase(n_tab[i]);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/twhsm_pkg.sv
src/twhsm_cfg.sv
src/twhsm_core.sv
src/twhsm_out_buf.sv
src/two_wire_humidity_sensor_master.sv
tb/twhsm_checker.sv
tb/two_wire_humidity_sensor_master_test.sv
